[rtl/llrd_pkg.sv]
package llrd_pkg;

	localparam int ITEM_COPIES    = 4;
	localparam int COPY_IDX_W     = 2;
	localparam int NODE_W         = 4;
	localparam int BLOCK_W        = 16;
	localparam int LOAD_W         = 16;
	localparam int MASK_W         = 16;
	localparam int COUNT_W        = 3;
	localparam int FIFO_DEPTH     = 2;

	localparam int NODE_COUNT_DEF = 16;
	localparam int MAX_COPIES_DEF = 4;

	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	localparam logic [1:0] CMD_ASSIGN  = 2'd0;
	localparam logic [1:0] CMD_CHARGE  = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [1:0] ST_ASSIGNED = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_UPDATED  = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [COUNT_W-1:0] copy_count;
		logic [NODE_W-1:0]  copy_node_0;
		logic [NODE_W-1:0]  copy_node_1;
		logic [NODE_W-1:0]  copy_node_2;
		logic [NODE_W-1:0]  copy_node_3;
		logic [BLOCK_W-1:0] copy_block_0;
		logic [BLOCK_W-1:0] copy_block_1;
		logic [BLOCK_W-1:0] copy_block_2;
		logic [BLOCK_W-1:0] copy_block_3;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [NODE_W-1:0]  chosen_node;
		logic [BLOCK_W-1:0] chosen_block;
		logic [LOAD_W-1:0]  node_load;
	} result_t;

	// classified work for the back end
	typedef struct packed {
		logic [1:0]                           cmd;
		logic [ITEM_COPIES-1:0]               cand;
		logic [COPY_IDX_W-1:0]                last_idx;
		logic [ITEM_COPIES-1:0][NODE_W-1:0]   node;
		logic [ITEM_COPIES-1:0][BLOCK_W-1:0]  block;
	} job_t;

endpackage

[rtl/least_loaded_replica_dispatch_core.sv]
// Channel   Handshake                 Payload
// item      start / busy              item   (llrd_pkg::item_t)
// config    cfg_valid / cfg_ready     cfg_data (node available mask)
// result    done strobe, no stall     result (llrd_pkg::result_t)
//
// Items are classified on acceptance and queued (two entries) for the back end.
// Back end scans n copies (1 to 4), one load table read per copy through the
// single read port, then compares and updates; it pops the next item when idle.
// busy is high while the queue is full. cfg_ready is always high.
// Reset clears the mask, queue and load table valid bits at once.
// done is high for one cycle per result; the receiver cannot stall.
module least_loaded_replica_dispatch_core #(
	parameter int NODE_COUNT = llrd_pkg::NODE_COUNT_DEF,
	parameter int MAX_COPIES = llrd_pkg::MAX_COPIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  llrd_pkg::item_t             item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [llrd_pkg::MASK_W-1:0] cfg_data,
	output logic                        done,
	output llrd_pkg::result_t           result
);

	logic           push;
	logic           q_full;
	logic           q_empty;
	logic           pop;
	llrd_pkg::job_t wr_job;
	llrd_pkg::job_t rd_job;

	assign busy      = q_full;
	assign cfg_ready = 1'b1;

	llrd_front #(
		.NODE_COUNT(NODE_COUNT),
		.MAX_COPIES(MAX_COPIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.job      (wr_job)
	);

	llrd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(wr_job),
		.full  (q_full),
		.pop   (pop),
		.rd_job(rd_job),
		.empty (q_empty)
	);

	llrd_back #(
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (q_empty),
		.job   (rd_job),
		.pop   (pop),
		.done  (done),
		.result(result)
	);

endmodule

[rtl/llrd_front.sv]
module llrd_front #(
	parameter int NODE_COUNT = llrd_pkg::NODE_COUNT_DEF,
	parameter int MAX_COPIES = llrd_pkg::MAX_COPIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  llrd_pkg::item_t             item,
	input  logic                        cfg_valid,
	input  logic [llrd_pkg::MASK_W-1:0] cfg_data,
	input  logic                        q_full,
	output logic                        push,
	output llrd_pkg::job_t              job
);

	localparam int CLAMP = (MAX_COPIES < llrd_pkg::ITEM_COPIES) ? MAX_COPIES
		: llrd_pkg::ITEM_COPIES;

	logic [llrd_pkg::MASK_W-1:0]    mask_q;
	logic [llrd_pkg::COUNT_W-1:0]   cnt;
	logic [llrd_pkg::ITEM_COPIES-1:0] in_tab;
	logic [llrd_pkg::ITEM_COPIES-1:0] avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid) begin
			mask_q <= cfg_data;
		end
	end

	assign push = start && !q_full;

	always_comb begin
		job.cmd      = item.cmd;
		job.node[0]  = item.copy_node_0;
		job.node[1]  = item.copy_node_1;
		job.node[2]  = item.copy_node_2;
		job.node[3]  = item.copy_node_3;
		job.block[0] = item.copy_block_0;
		job.block[1] = item.copy_block_1;
		job.block[2] = item.copy_block_2;
		job.block[3] = item.copy_block_3;

		cnt = (item.copy_count > llrd_pkg::COUNT_W'(CLAMP))
			? llrd_pkg::COUNT_W'(CLAMP) : item.copy_count;

		for (int i = 0; i < llrd_pkg::ITEM_COPIES; i++) begin
			in_tab[i] = 32'(job.node[i]) < NODE_COUNT;
			avail[i]  = in_tab[i] && mask_q[job.node[i]]
				&& (llrd_pkg::COUNT_W'(i) < cnt);
		end

		job.cand     = '0;
		job.last_idx = '0;
		if (item.cmd == llrd_pkg::CMD_ASSIGN) begin
			job.cand = avail;
			if (cnt != '0) begin
				job.last_idx = llrd_pkg::COPY_IDX_W'(cnt - llrd_pkg::COUNT_W'(1));
			end
		end else if (item.cmd == llrd_pkg::CMD_CHARGE
				|| item.cmd == llrd_pkg::CMD_RELEASE) begin
			job.cand[0] = in_tab[0];
		end
	end

endmodule

[rtl/llrd_fifo.sv]
module llrd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  llrd_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output llrd_pkg::job_t rd_job,
	output logic           empty
);

	localparam int PTR_W = (llrd_pkg::FIFO_DEPTH > 1) ? $clog2(llrd_pkg::FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(llrd_pkg::FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(llrd_pkg::FIFO_DEPTH - 1);

	llrd_pkg::job_t   slot_q [llrd_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = cnt_q == CNT_W'(llrd_pkg::FIFO_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/llrd_back.sv]
module llrd_back #(
	parameter int NODE_COUNT = llrd_pkg::NODE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  llrd_pkg::job_t   job,
	output logic             pop,
	output logic             done,
	output llrd_pkg::result_t result
);

	localparam int DEPTH  = (NODE_COUNT < 16) ? NODE_COUNT : 16;
	localparam int TIDX_W = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_UPD   = 4'b1000
	} state_t;

	state_t                              state_q;
	llrd_pkg::job_t                      cur_q;
	logic [llrd_pkg::COPY_IDX_W-1:0]     idx_q;
	logic                                rd_pend_s1;
	logic                                rd_cand_s1;
	logic [llrd_pkg::COPY_IDX_W-1:0]     rd_idx_s1;
	logic                                rd_vld_s1;
	logic [llrd_pkg::LOAD_W-1:0]         rd_data_s1;
	logic                                found_q;
	logic [llrd_pkg::COPY_IDX_W-1:0]     best_idx_q;
	logic [llrd_pkg::LOAD_W-1:0]         best_load_q;
	logic                                done_q;
	llrd_pkg::result_t                   result_q;

	logic [llrd_pkg::LOAD_W-1:0]         mem [DEPTH];
	logic [DEPTH-1:0]                    vld_q;

	logic [TIDX_W-1:0]                   rd_addr;
	logic [TIDX_W-1:0]                   wr_addr;
	logic                                wr_en;
	logic [llrd_pkg::LOAD_W-1:0]         wr_data;
	logic [llrd_pkg::LOAD_W-1:0]         ld;
	logic                                take;
	logic [llrd_pkg::LOAD_W-1:0]         inc;
	logic [llrd_pkg::LOAD_W-1:0]         dec;
	logic [llrd_pkg::NODE_W-1:0]         sel_node;
	llrd_pkg::result_t                   res_d;

	assign pop     = (state_q == S_IDLE) && !empty;
	assign done    = done_q;
	assign result  = result_q;
	assign rd_addr = cur_q.node[idx_q][TIDX_W-1:0];
	assign sel_node = cur_q.node[best_idx_q];
	assign wr_addr = sel_node[TIDX_W-1:0];

	assign ld   = rd_vld_s1 ? rd_data_s1 : '0;
	assign take = rd_pend_s1 && rd_cand_s1 && (!found_q || ld < best_load_q);
	assign inc  = (best_load_q == llrd_pkg::LOAD_MAX) ? best_load_q
		: best_load_q + llrd_pkg::LOAD_W'(1);
	assign dec  = (best_load_q == '0) ? best_load_q : best_load_q - llrd_pkg::LOAD_W'(1);

	always_comb begin
		res_d   = '0;
		wr_en   = 1'b0;
		wr_data = inc;
		unique case (cur_q.cmd)
			llrd_pkg::CMD_ASSIGN: begin
				res_d.status = llrd_pkg::ST_NONE;
				if (found_q) begin
					wr_en              = 1'b1;
					res_d.status       = llrd_pkg::ST_ASSIGNED;
					res_d.chosen_node  = sel_node;
					res_d.chosen_block = cur_q.block[best_idx_q];
					res_d.node_load    = inc;
				end
			end
			llrd_pkg::CMD_CHARGE, llrd_pkg::CMD_RELEASE: begin
				res_d.status      = llrd_pkg::ST_UPDATED;
				res_d.chosen_node = cur_q.node[0];
				if (found_q) begin
					wr_en           = 1'b1;
					wr_data         = (cur_q.cmd == llrd_pkg::CMD_CHARGE) ? inc : dec;
					res_d.node_load = wr_data;
				end
			end
			default: begin
				res_d.status = llrd_pkg::ST_NONE;
			end
		endcase
		if (state_q != S_UPD) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
		if (pop) begin
			cur_q <= job;
		end
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_load_q <= ld;
		end
		if (state_q == S_UPD) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_cand_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
			vld_q      <= '0;
		end else begin
			rd_pend_s1 <= state_q == S_SCAN;
			rd_cand_s1 <= cur_q.cand[idx_q];
			rd_idx_s1  <= idx_q;
			rd_vld_s1  <= vld_q[rd_addr];
			done_q     <= state_q == S_UPD;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + llrd_pkg::COPY_IDX_W'(1);
					if (idx_q == cur_q.last_idx) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_UPD))
		else $error("result strobe without update step");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == S_SCAN))
		else $error("load read returned outside scan");

	a_assigned_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == llrd_pkg::ST_ASSIGNED) |-> result_q.node_load != '0)
		else $error("assigned node reports zero load");

endmodule

[tb/sv/tb_least_loaded_replica_dispatch_core.sv]
module tb_least_loaded_replica_dispatch_core;

	import llrd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NODE_TOTAL = NODE_COUNT_DEF;
	localparam int COPY_LIMIT = MAX_COPIES_DEF;
	localparam int SETTLE_CYCLES = 10;
	localparam int PRINT_CAP = 100;

	typedef struct {
		bit          mask_write;
		logic [15:0] mask;
		item_t       it;
	} work_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item_drv = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MASK_W-1:0] cfg_data = '0;
	logic done;
	result_t result_w;

	work_t work_q[$];
	result_t outcome_q[$];

	logic [LOAD_W-1:0] node_loads [NODE_TOTAL];
	logic [MASK_W-1:0] avail_mask = '0;

	int n_issued = 0;
	int n_reported = 0;
	int mismatches = 0;
	int quiet = 0;
	int burst_left = 0;
	int gap_left = 0;
	work_t head;
	result_t want;

	least_loaded_replica_dispatch_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item_drv),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result_w)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (node_loads[i]) node_loads[i] = '0;
	end

	function automatic result_t dispatch_outcome(input item_t it);
		result_t r;
		logic [NODE_W-1:0] nodes [ITEM_COPIES];
		logic [BLOCK_W-1:0] blocks [ITEM_COPIES];
		int span;
		int pick;
		logic [LOAD_W-1:0] pick_load;
		logic [NODE_W-1:0] n;
		r = '0;
		nodes = '{it.copy_node_0, it.copy_node_1, it.copy_node_2, it.copy_node_3};
		blocks = '{it.copy_block_0, it.copy_block_1, it.copy_block_2, it.copy_block_3};
		pick = -1;
		pick_load = '0;
		case (it.cmd)
			CMD_ASSIGN: begin
				span = it.copy_count;
				if (span > COPY_LIMIT) span = COPY_LIMIT;
				if (span > ITEM_COPIES) span = ITEM_COPIES;
				for (int i = 0; i < span; i++) begin
					if (nodes[i] < NODE_TOTAL && avail_mask[nodes[i]] &&
					    (pick < 0 || node_loads[nodes[i]] < pick_load)) begin
						pick = i;
						pick_load = node_loads[nodes[i]];
					end
				end
				if (pick < 0) begin
					r.status = ST_NONE;
				end else begin
					n = nodes[pick];
					if (node_loads[n] != LOAD_MAX) node_loads[n] = node_loads[n] + 1'b1;
					r.status = ST_ASSIGNED;
					r.chosen_node = n;
					r.chosen_block = blocks[pick];
					r.node_load = node_loads[n];
				end
			end
			CMD_CHARGE, CMD_RELEASE: begin
				n = nodes[0];
				r.status = ST_UPDATED;
				r.chosen_node = n;
				if (n < NODE_TOTAL) begin
					if (it.cmd == CMD_CHARGE) begin
						if (node_loads[n] != LOAD_MAX) node_loads[n] = node_loads[n] + 1'b1;
					end else if (node_loads[n] != '0) begin
						node_loads[n] = node_loads[n] - 1'b1;
					end
					r.node_load = node_loads[n];
				end
			end
			default: begin
				r.status = ST_NONE;
			end
		endcase
		return r;
	endfunction

	function automatic item_t random_item();
		item_t it;
		logic [95:0] raw;
		int unsigned roll;
		raw = {$urandom(), $urandom(), $urandom()};
		it = raw[$bits(item_t)-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 62) begin
			it.cmd = CMD_ASSIGN;
			it.copy_count = COUNT_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
			                                                      : $urandom_range(0, 7));
		end else if (roll < 80) begin
			it.cmd = CMD_CHARGE;
		end else if (roll < 96) begin
			it.cmd = CMD_RELEASE;
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic queue_item(input item_t it);
		work_t w;
		w.mask_write = 1'b0;
		w.mask = '0;
		w.it = it;
		work_q.push_back(w);
	endtask

	task automatic queue_mask(input logic [MASK_W-1:0] mask);
		work_t w;
		w.mask_write = 1'b1;
		w.mask = mask;
		w.it = '0;
		work_q.push_back(w);
	endtask

	task automatic check_field(input string label, input logic [15:0] exp_v, input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s expected %0h actual %0h", $time, label, exp_v, act_v);
		end
	endtask

	// driver: bursts of transactions with random gaps, mask writes only once drained
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (n_issued == n_reported && !start && !cfg_valid) quiet++;
			else quiet = 0;
			if (start && !busy) begin
				outcome_q.push_back(dispatch_outcome(item_drv));
				n_issued++;
			end
			if (cfg_valid && cfg_ready) avail_mask = cfg_data;
			if ((start && busy) || (cfg_valid && !cfg_ready)) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
				gap_left--;
			end else if (work_q.size() == 0) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (work_q[0].mask_write) begin
				start <= 1'b0;
				if (quiet >= SETTLE_CYCLES) begin
					head = work_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_data <= head.mask;
				end else begin
					cfg_valid <= 1'b0;
				end
			end else begin
				head = work_q.pop_front();
				start <= 1'b1;
				item_drv <= head.it;
				cfg_valid <= 1'b0;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					gap_left = $urandom_range(1, 8);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
					                                        : $urandom_range(1, 12);
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_reported <= n_reported + 1;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: result expected none actual %0h", $time, result_w);
			end else begin
				want = outcome_q.pop_front();
				check_field("status", want.status, result_w.status);
				check_field("chosen_node", want.chosen_node, result_w.chosen_node);
				check_field("chosen_block", want.chosen_block, result_w.chosen_block);
				check_field("node_load", want.node_load, result_w.node_load);
			end
		end
	end

	initial begin
		logic [MASK_W-1:0] phase_masks [8];
		int phase_items [8];
		phase_masks = '{16'hFFFF, 16'h5555, 16'hAAAA, 16'(($urandom())), 16'h0000,
		                16'(($urandom())), 16'h8001, 16'hFFFF};
		phase_items = '{200, 180, 180, 200, 40, 200, 180, 220};

		// mask still at its reset value: nothing can be assigned
		queue_item(item_t'{CMD_ASSIGN, 3'd2, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'h0001, 16'h0002, 16'h0003, 16'h0004});
		queue_mask(16'hFFFF);
		queue_item(item_t'{CMD_ASSIGN, 3'd0, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'h1111, 16'h2222, 16'h3333, 16'h4444});
		queue_item(item_t'{CMD_ASSIGN, 3'd4, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'h0000, 16'hFFFF, 16'h1234, 16'h8000});
		queue_item(item_t'{CMD_ASSIGN, 3'd4, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'h0000, 16'hFFFF, 16'h1234, 16'h8000});
		queue_item(item_t'{CMD_ASSIGN, 3'd7, 4'd3, 4'd3, 4'd2, 4'd1,
		                   16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00});
		queue_item(item_t'{CMD_ASSIGN, 3'd5, 4'd15, 4'd14, 4'd13, 4'd12,
		                   16'hFFFF, 16'hFFFE, 16'h7FFF, 16'h0001});
		queue_item(item_t'{CMD_ASSIGN, 3'd6, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'hDEAD, 16'hBEEF, 16'hCAFE, 16'hF00D});
		queue_item(item_t'{CMD_ASSIGN, 3'd1, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_CHARGE, 3'd0, 4'd0, 4'd15, 4'd15, 4'd15,
		                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		queue_item(item_t'{CMD_CHARGE, 3'd7, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_RELEASE, 3'd4, 4'd4, 4'd1, 4'd2, 4'd3,
		                   16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
		queue_item(item_t'{CMD_RELEASE, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_UNUSED, 3'd7, 4'd15, 4'd15, 4'd15, 4'd15,
		                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		queue_item(item_t'{CMD_ASSIGN, 3'd3, 4'd7, 4'd7, 4'd7, 4'd9,
		                   16'h0007, 16'h0070, 16'h0700, 16'h7000});
		queue_item(item_t'{CMD_ASSIGN, 3'd2, 4'd8, 4'd8, 4'd0, 4'd0,
		                   16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
		queue_mask(16'h00F0);
		queue_item(item_t'{CMD_ASSIGN, 3'd4, 4'd0, 4'd1, 4'd4, 4'd5,
		                   16'h0101, 16'h0202, 16'h0404, 16'h0505});
		queue_item(item_t'{CMD_ASSIGN, 3'd4, 4'd0, 4'd1, 4'd2, 4'd3,
		                   16'h0101, 16'h0202, 16'h0303, 16'h0404});
		queue_item(item_t'{CMD_CHARGE, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});

		// only node 15 available: assign to it, then move its load both ways
		queue_mask(16'h8000);
		queue_item(item_t'{CMD_ASSIGN, 3'd1, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'hBEEF, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_ASSIGN, 3'd2, 4'd0, 4'd15, 4'd0, 4'd0,
		                   16'h0001, 16'hFACE, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_RELEASE, 3'd0, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_CHARGE, 3'd0, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});
		queue_item(item_t'{CMD_CHARGE, 3'd0, 4'd15, 4'd0, 4'd0, 4'd0,
		                   16'h0000, 16'h0000, 16'h0000, 16'h0000});

		for (int p = 0; p < 8; p++) begin
			queue_mask(phase_masks[p]);
			repeat (phase_items[p]) queue_item(random_item());
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (work_q.size() == 0);
		do @(negedge clk); while (start || cfg_valid || n_issued != n_reported);
		repeat (20) @(negedge clk);
		if (outcome_q.size() != 0) begin
			mismatches++;
			$display("%0t: results expected %0d more actual 0", $time, outcome_q.size());
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[least_loaded_replica_dispatch_core.f]
rtl/llrd_pkg.sv
rtl/llrd_front.sv
rtl/llrd_fifo.sv
rtl/llrd_back.sv
rtl/least_loaded_replica_dispatch_core.sv
tb/sv/tb_least_loaded_replica_dispatch_core.sv
